FILE: rtl/rah_pkg.sv
`default_nettype none
package rah_pkg;

    // Width of a slab distance t, signed Q32.16.
    localparam int T_W = 48;
    // One quotient bit is settled in each divider stage.
    localparam int DIV_LAT = T_W;

    localparam logic signed [T_W-1:0] T_MAX  = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN  = {1'b1, {(T_W-1){1'b0}}};
    // Minus one in Q32.16: the distance of an axis that gives no plane.
    localparam logic signed [T_W-1:0] T_NONE = -48'sd65536;

    localparam logic [15:0] TOL_RESET = 16'd7;

    // Ray and box coordinates that ride along with an item.
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
        logic             in_box;
    } t_side;

    // What travels beside the divider.
    typedef struct packed {
        logic       vld;
        t_side      side;
        logic [2:0] neg;
        logic [2:0] use_q;
    } t_carry;

endpackage
`default_nettype wire

FILE: rtl/rah_div.sv
`default_nettype none
module rah_div
    import rah_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic [T_W-1:0] i_num,
    input  wire logic [31:0]    i_den,
    output logic      [T_W-1:0] o_quo
);

    // Unsigned restoring division, one quotient bit per register stage.
    logic [31:0]    r_rem [DIV_LAT];
    logic [T_W-1:0] r_num [DIV_LAT];
    logic [31:0]    r_den [DIV_LAT];
    logic [T_W-1:0] r_quo [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
        logic [31:0]    rem_in;
        logic [T_W-1:0] num_in;
        logic [31:0]    den_in;
        logic [T_W-1:0] quo_in;
        logic [32:0]    trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, num_in[T_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
            r_num[k] <= {num_in[T_W-2:0], 1'b0};
            r_den[k] <= den_in;
            r_quo[k] <= {quo_in[T_W-2:0], ge};
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];

endmodule
`default_nettype wire

FILE: rtl/ray_aabb_hit_test.sv
// Channel   Ports                                   Handshake
// input     i_origin_*, i_dir_*, i_box_min_*,       accepted when start is high
//           i_box_max_*                             and busy is low
// result    o_hit                                   o_done high for one cycle
// config    i_cfg_wdata (bound tolerance)           written when i_cfg_we is high
//
// Each item passes from its accepting edge to o_done through capture, slab
// test, a 48-stage divider (one quotient bit per stage) and five stages of pick,
// product, saturation and bound check. Busy stays low, so an item can enter in
// every cycle. Reset is synchronous and active low; it clears every valid bit
// and sets the tolerance to 7. The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module ray_aabb_hit_test
    import rah_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic signed [31:0] i_box_min_x,
    input  wire logic signed [31:0] i_box_min_y,
    input  wire logic signed [31:0] i_box_min_z,
    input  wire logic signed [31:0] i_box_max_x,
    input  wire logic signed [31:0] i_box_max_y,
    input  wire logic signed [31:0] i_box_max_z,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output logic             o_hit
);

    // The pipeline never holds, so an item is taken in every cycle.
    assign busy = 1'b0;

    logic [15:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Stage A: capture the item.
    logic  r_a_vld;
    t_side r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side.org    <= {i_origin_z, i_origin_y, i_origin_x};
        r_a_side.dir    <= {i_dir_z, i_dir_y, i_dir_x};
        r_a_side.lo     <= {i_box_min_z, i_box_min_y, i_box_min_x};
        r_a_side.hi     <= {i_box_max_z, i_box_max_y, i_box_max_x};
        r_a_side.in_box <= 1'b0;
    end

    // Stage B: slab tests and divider operands. For each axis outside its
    // slab, the distance numerator is the gap to the near face scaled by 2^16;
    // the division runs on magnitudes and the sign is put back afterwards.
    logic [2:0]           n_b_out;
    logic [2:0]           n_b_neg;
    logic [2:0]           n_b_use;
    logic [2:0][T_W-1:0]  n_b_num;
    logic [2:0][31:0]     n_b_den;
    t_side                n_b_side;
    logic [2:0][T_W-1:0]  r_b_num;
    logic [2:0][31:0]     r_b_den;
    t_carry               r_b_car;

    always_comb begin
        logic signed [31:0] o, d, lo, hi;
        logic               below, above;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        for (int a = 0; a < 3; a++) begin
            o     = $signed(r_a_side.org[a]);
            d     = $signed(r_a_side.dir[a]);
            lo    = $signed(r_a_side.lo[a]);
            hi    = $signed(r_a_side.hi[a]);
            below = o < lo;
            above = !below && (o > hi);
            diff  = below ? (33'(lo) - 33'(o)) : (33'(hi) - 33'(o));
            mag   = diff[32] ? 33'(-diff) : 33'(diff);
            n_b_out[a] = below || above;
            n_b_neg[a] = above ^ d[31];
            n_b_use[a] = (below || above) && (d != 0);
            n_b_num[a] = {mag[31:0], 16'h0000};
            n_b_den[a] = d[31] ? 32'(-d) : 32'(d);
        end
        n_b_side        = r_a_side;
        n_b_side.in_box = ~|n_b_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_car.vld <= 1'b0;
        end else begin
            r_b_car.vld <= r_a_vld;
        end
        r_b_num       <= n_b_num;
        r_b_den       <= n_b_den;
        r_b_car.side  <= n_b_side;
        r_b_car.neg   <= n_b_neg;
        r_b_car.use_q <= n_b_use;
    end

    // Divider pipelines, one per axis, with a matching delay line beside them.
    logic [2:0][T_W-1:0] quo;

    for (genvar a = 0; a < 3; a++) begin : g_div
        rah_div u_div (
            .i_clk (i_clk),
            .i_num (r_b_num[a]),
            .i_den (r_b_den[a]),
            .o_quo (quo[a])
        );
    end

    t_carry r_dl [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl[k].vld <= 1'b0;
                end else begin
                    r_dl[k].vld <= r_b_car.vld;
                end
                r_dl[k].side  <= r_b_car.side;
                r_dl[k].neg   <= r_b_car.neg;
                r_dl[k].use_q <= r_b_car.use_q;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl[k].vld <= 1'b0;
                end else begin
                    r_dl[k].vld <= r_dl[k-1].vld;
                end
                r_dl[k].side  <= r_dl[k-1].side;
                r_dl[k].neg   <= r_dl[k-1].neg;
                r_dl[k].use_q <= r_dl[k-1].use_q;
            end
        end
    end

    t_carry car_q;
    assign car_q = r_dl[DIV_LAT-1];

    // Stage C: signed, saturated distances; axes that give no plane keep -1.0.
    logic [2:0][T_W-1:0] n_c_t;
    logic [2:0][T_W-1:0] r_c_t;
    logic                r_c_vld;
    t_side               r_c_side;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!car_q.use_q[a]) begin
                n_c_t[a] = T_NONE;
            end else if (car_q.neg[a]) begin
                n_c_t[a] = (quo[a] > {1'b1, {(T_W-1){1'b0}}}) ? T_MIN : T_W'(-quo[a]);
            end else begin
                n_c_t[a] = quo[a][T_W-1] ? T_MAX : quo[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= car_q.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_t    <= n_c_t;
        r_c_side <= car_q.side;
    end

    // Stage D: the largest distance picks the plane, the lowest axis on ties.
    logic [1:0]            n_d_pick;
    logic signed [T_W-1:0] n_d_tp;
    logic [1:0]            r_d_pick;
    logic signed [T_W-1:0] r_d_tp;
    logic                  r_d_vld;
    t_side                 r_d_side;

    always_comb begin
        n_d_pick = 2'd0;
        n_d_tp   = $signed(r_c_t[0]);
        if ($signed(r_c_t[1]) > n_d_tp) begin
            n_d_pick = 2'd1;
            n_d_tp   = $signed(r_c_t[1]);
        end
        if ($signed(r_c_t[2]) > n_d_tp) begin
            n_d_pick = 2'd2;
            n_d_tp   = $signed(r_c_t[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_pick <= n_d_pick;
        r_d_tp   <= n_d_tp;
        r_d_side <= r_c_side;
    end

    // Stage E: partial products of t by each direction magnitude. A negative
    // t means a miss, so only the non-negative case needs a correct product.
    logic [2:0][63:0] r_e_ph;
    logic [2:0][47:0] r_e_pl;
    logic [2:0]       r_e_neg;
    logic [1:0]       r_e_pick;
    logic             r_e_miss;
    logic             r_e_vld;
    t_side            r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] md;
        for (int a = 0; a < 3; a++) begin
            md = r_d_side.dir[a][31] ? 32'(-r_d_side.dir[a]) : r_d_side.dir[a];
            r_e_ph[a]  <= 64'(r_d_tp[47:16]) * 64'(md);
            r_e_pl[a]  <= 48'(r_d_tp[15:0]) * 48'(md);
            r_e_neg[a] <= r_d_side.dir[a][31];
        end
        r_e_pick <= r_d_pick;
        r_e_miss <= r_d_tp[T_W-1];
        r_e_side <= r_d_side;
    end

    // Stage F: combine, apply sign and saturate to Q32.16.
    logic [2:0][T_W-1:0] n_f_prod;
    logic [2:0][T_W-1:0] r_f_prod;
    logic [1:0]          r_f_pick;
    logic                r_f_miss;
    logic                r_f_vld;
    t_side               r_f_side;

    always_comb begin
        logic [63:0] p;
        for (int a = 0; a < 3; a++) begin
            p = r_e_ph[a] + 64'(r_e_pl[a][47:16]);
            if (r_e_neg[a]) begin
                n_f_prod[a] = (p > 64'h0000_8000_0000_0000) ? T_MIN : T_W'(-p);
            end else begin
                n_f_prod[a] = (p > 64'h0000_7FFF_FFFF_FFFF) ? T_MAX : p[T_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_prod <= n_f_prod;
        r_f_pick <= r_e_pick;
        r_f_miss <= r_e_miss;
        r_f_side <= r_e_side;
    end

    // Stage G: hit point on the two other axes against the widened bounds.
    logic       n_g_hit;
    logic [2:0] ax_ok;
    logic       r_g_hit;
    logic       r_g_vld;

    always_comb begin
        logic signed [49:0] c, lo_w, hi_w;
        for (int a = 0; a < 3; a++) begin
            c    = 50'($signed(r_f_side.org[a])) + 50'($signed(r_f_prod[a]));
            lo_w = 50'($signed(r_f_side.lo[a])) - $signed({34'd0, r_tol});
            hi_w = 50'($signed(r_f_side.hi[a])) + $signed({34'd0, r_tol});
            ax_ok[a] = (r_f_pick == 2'(a)) || ((c >= lo_w) && (c <= hi_w));
        end
        n_g_hit = r_f_side.in_box || (!r_f_miss && (&ax_ok));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_hit <= n_g_hit;
    end

    assign o_done = r_g_vld;
    assign o_hit  = r_g_hit;

    // The chosen plane index is always one of the three axes.
    a_pick_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> (r_d_pick != 2'd3))
        else $error("plane index out of range");

    // A picked distance below zero is only possible when no axis gave a plane
    // of non-negative distance, so every stage C distance was negative; checked here for axis 0.
    a_pick_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && !r_c_t[0][T_W-1]) |=> !r_d_tp[T_W-1])
        else $error("picked distance is not the largest");

    // An origin inside the box in stage F gives a hit in the next cycle.
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_vld && r_f_side.in_box) |=> o_hit)
        else $error("inside origin reported as miss");

    // An axis that gives no plane carries exactly minus one into the pick; checked here for axis 0.
    a_none_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (car_q.vld && !car_q.use_q[0]) |=> (r_c_t[0] == T_NONE))
        else $error("unused axis distance is not minus one");

endmodule
`default_nettype wire
